// ===== hdl/spmd_pkg.sv =====
package spmd_pkg;

   localparam int DATA_W           = 32;
   localparam int VEC_W            = 3 * DATA_W;
   localparam int PROD_W           = 2 * DATA_W;
   // three full products plus a shifted translation need 65 bits; one spare
   localparam int SUM_W            = PROD_W + 2;
   localparam int CSR_W            = 11;
   localparam int IDX_W            = 10;
   localparam int ACT_W            = 2;

   localparam int MAX_VERTICES_DEF = 1024;
   localparam int FRAC_BITS_DEF    = 16;

   localparam logic [ACT_W-1:0] ACT_LOAD_VTX = 2'd0;
   localparam logic [ACT_W-1:0] ACT_LOAD_ROW = 2'd1;
   localparam logic [ACT_W-1:0] ACT_QUERY    = 2'd2;

   // what a result leaving the dot unit belongs to
   typedef enum logic [1:0] {
      KIND_DIR = 2'd0,
      KIND_DOT = 2'd1,
      KIND_XF  = 2'd2
   } kind_type;

   localparam logic signed [SUM_W-1:0] Q_HI = 66'sd2147483647;
   localparam logic signed [SUM_W-1:0] Q_LO = -66'sd2147483648;

   // floor to the fixed-point grid, then clamp to 32 bits
   function automatic logic signed [DATA_W-1:0] q_sat(input logic signed [SUM_W-1:0] s,
                                                      input int unsigned frac);
      logic signed [SUM_W-1:0] sh;
      sh = s >>> frac;
      if (sh > Q_HI) begin
         q_sat = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (sh < Q_LO) begin
         q_sat = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         q_sat = sh[DATA_W-1:0];
      end
   endfunction

endpackage

// ===== hdl/support_point_max_dot.sv =====
// Support-point search for collision tests. Vertex loads (action 0) and matrix row
// loads (action 1) are taken while idle and busy stays low. A query (action 2)
// rotates the direction into model space, walks the stored vertices one per cycle
// through the shared three-lane dot-product unit, re-reads the winner from the vertex
// RAM and maps it to world space through the same unit. The vertex walk covers
// vertex_count vertices, clamped to MAX_VERTICES, and is skipped for an empty mesh.
// The result is shown for one cycle only and cannot be held off, so the receiver
// must take it then. A new item may be started in the cycle the result is shown.
module support_point_max_dot import spmd_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [ACT_W-1:0]         req_action,
   input  logic [IDX_W-1:0]         req_index,
   input  logic signed [DATA_W-1:0] req_val_a,
   input  logic signed [DATA_W-1:0] req_val_b,
   input  logic signed [DATA_W-1:0] req_val_c,
   input  logic signed [DATA_W-1:0] req_val_d,
   input  logic                     csr_we,
   input  logic [CSR_W-1:0]         csr_wdata,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_world_x,
   output logic signed [DATA_W-1:0] rsp_world_y,
   output logic signed [DATA_W-1:0] rsp_world_z,
   output logic                     rsp_empty_mesh
);

   localparam int AW    = $clog2(MAX_VERTICES);
   localparam int CW    = ($clog2(MAX_VERTICES + 1) > CSR_W) ? $clog2(MAX_VERTICES + 1)
                                                              : CSR_W;
   localparam int TAG_W = 2 + AW;
   localparam logic signed [DATA_W-1:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

   typedef enum logic [8:0] {
      S_IDLE       = 9'b000000001,
      S_DIR        = 9'b000000010,
      S_DIR_WAIT   = 9'b000000100,
      S_WALK       = 9'b000001000,
      S_WALK_WAIT  = 9'b000010000,
      S_FETCH      = 9'b000100000,
      S_LATCH      = 9'b001000000,
      S_XFORM      = 9'b010000000,
      S_XFORM_WAIT = 9'b100000000
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [CSR_W-1:0]        vcount_ff, vcount_in;
   logic signed [DATA_W-1:0] mat_ff [3][4];
   logic signed [DATA_W-1:0] mat_in [3][4];
   logic signed [DATA_W-1:0] dir_ff [3];
   logic signed [DATA_W-1:0] dir_in [3];
   logic signed [DATA_W-1:0] md_ff [3];
   logic signed [DATA_W-1:0] md_in [3];
   logic signed [DATA_W-1:0] p_ff [3];
   logic signed [DATA_W-1:0] p_in [3];
   logic signed [DATA_W-1:0] world_ff [3];
   logic signed [DATA_W-1:0] world_in [3];
   logic signed [SUM_W-1:0] best_ff, best_in;
   logic [AW-1:0]           best_slot_ff, best_slot_in;
   logic                    have_ff, have_in;
   logic                    empty_ff, empty_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [AW-1:0]           rd_slot_ff, rd_slot_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    accept;
   logic [CW-1:0]           vcount_ext;
   logic [CW-1:0]           n_eff;
   logic [CW-1:0]           n_minus;
   logic [AW-1:0]           last_slot;
   logic [AW+IDX_W-1:0]     idx_wide;
   logic                    vtx_in_range;
   logic                    mem_we;
   logic                    mem_re;
   logic [AW-1:0]           mem_raddr;
   logic [VEC_W-1:0]        mem_rdata;
   logic signed [DATA_W-1:0] vtx [3];
   logic [1:0]              sel;

   logic                    du_valid;
   logic [TAG_W-1:0]        du_tag;
   logic signed [DATA_W-1:0] du_a [3];
   logic signed [DATA_W-1:0] du_b [3];
   logic signed [SUM_W-1:0] du_bias;
   logic                    out_valid;
   logic [TAG_W-1:0]        out_tag;
   logic signed [SUM_W-1:0] out_sum;
   kind_type                out_kind;
   logic [AW-1:0]           out_idx;
   logic signed [DATA_W-1:0] out_q;

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign vcount_ext = CW'(vcount_ff);
   assign n_eff      = (vcount_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vcount_ext;
   assign n_minus    = n_eff - CW'(1);
   assign last_slot  = n_minus[AW-1:0];
   assign sel        = cnt_ff[1:0];

   assign idx_wide     = (AW + IDX_W)'(req_index);
   assign vtx_in_range = ({{(32-IDX_W){1'b0}}, req_index} < 32'(MAX_VERTICES));
   assign mem_we       = accept && (req_action == ACT_LOAD_VTX) && vtx_in_range;
   assign mem_re       = (state_ff == S_WALK) || (state_ff == S_FETCH);
   assign mem_raddr    = (state_ff == S_WALK) ? cnt_ff[AW-1:0] : best_slot_ff;

   spmd_vmem #(
      .DEPTH (MAX_VERTICES),
      .AW    (AW)
   ) u_vmem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (idx_wide[AW-1:0]),
      .wr_data ({req_val_c, req_val_b, req_val_a}),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         vtx[k] = mem_rdata[k*DATA_W +: DATA_W];
      end
   end

   // operand selection for the shared dot unit
   always_comb begin
      du_valid = 1'b0;
      du_tag   = {KIND_DOT, rd_slot_ff};
      du_bias  = '0;
      for (int k = 0; k < 3; k++) begin
         du_a[k] = vtx[k];
         du_b[k] = md_ff[k];
      end
      if (state_ff == S_DIR) begin
         du_valid = 1'b1;
         du_tag   = {KIND_DIR, AW'(sel)};
         for (int r = 0; r < 3; r++) begin
            du_a[r] = mat_ff[r][sel];
            du_b[r] = dir_ff[r];
         end
      end else if (state_ff == S_XFORM) begin
         du_valid = 1'b1;
         du_tag   = {KIND_XF, AW'(sel)};
         du_bias  = SUM_W'(mat_ff[sel][3]) <<< FRAC_BITS;
         for (int c = 0; c < 3; c++) begin
            du_a[c] = mat_ff[sel][c];
            du_b[c] = p_ff[c];
         end
      end else if (rd_valid_ff) begin
         du_valid = 1'b1;
      end
   end

   spmd_dot3 #(
      .TAG_W (TAG_W)
   ) u_dot3 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (du_valid),
      .in_tag    (du_tag),
      .in_a      (du_a),
      .in_b      (du_b),
      .in_bias   (du_bias),
      .out_valid (out_valid),
      .out_tag   (out_tag),
      .out_sum   (out_sum)
   );

   assign out_kind = kind_type'(out_tag[TAG_W-1:AW]);
   assign out_idx  = out_tag[AW-1:0];
   assign out_q    = q_sat(out_sum, FRAC_BITS);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      vcount_in    = vcount_ff;
      mat_in       = mat_ff;
      dir_in       = dir_ff;
      md_in        = md_ff;
      p_in         = p_ff;
      world_in     = world_ff;
      best_in      = best_ff;
      best_slot_in = best_slot_ff;
      have_in      = have_ff;
      empty_in     = empty_ff;
      rd_valid_in  = (state_ff == S_WALK);
      rd_slot_in   = cnt_ff[AW-1:0];
      rsp_valid_in = 1'b0;

      if (csr_we) begin
         vcount_in = csr_wdata;
      end

      if (out_valid) begin
         case (out_kind)
            KIND_DIR: begin
               md_in[out_idx[1:0]] = out_q;
            end
            KIND_DOT: begin
               // strict compare keeps the earliest slot on a tie
               if (!have_ff || (out_sum > best_ff)) begin
                  best_in      = out_sum;
                  best_slot_in = out_idx;
               end
               have_in = 1'b1;
            end
            KIND_XF: begin
               world_in[out_idx[1:0]] = out_q;
            end
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_LOAD_ROW: begin
                     if (req_index < IDX_W'(3)) begin
                        mat_in[req_index[1:0]][0] = req_val_a;
                        mat_in[req_index[1:0]][1] = req_val_b;
                        mat_in[req_index[1:0]][2] = req_val_c;
                        mat_in[req_index[1:0]][3] = req_val_d;
                     end
                  end
                  ACT_QUERY: begin
                     dir_in[0] = req_val_a;
                     dir_in[1] = req_val_b;
                     dir_in[2] = req_val_c;
                     cnt_in    = '0;
                     state_in  = S_DIR;
                  end
                  default: ;
               endcase
            end
         end
         S_DIR: begin
            cnt_in = cnt_ff + CW'(1);
            if (sel == 2'd2) begin
               state_in = S_DIR_WAIT;
            end
         end
         S_DIR_WAIT: begin
            if (out_valid && (out_kind == KIND_DIR) && (out_idx == AW'(2))) begin
               cnt_in = '0;
               if (n_eff == '0) begin
                  empty_in = 1'b1;
                  state_in = S_LATCH;
               end else begin
                  empty_in = 1'b0;
                  have_in  = 1'b0;
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == n_minus) begin
               state_in = S_WALK_WAIT;
            end
         end
         S_WALK_WAIT: begin
            if (out_valid && (out_kind == KIND_DOT) && (out_idx == last_slot)) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_LATCH;
         end
         S_LATCH: begin
            for (int k = 0; k < 3; k++) begin
               p_in[k] = empty_ff ? '0 : vtx[k];
            end
            cnt_in   = '0;
            state_in = S_XFORM;
         end
         S_XFORM: begin
            cnt_in = cnt_ff + CW'(1);
            if (sel == 2'd2) begin
               state_in = S_XFORM_WAIT;
            end
         end
         S_XFORM_WAIT: begin
            if (out_valid && (out_kind == KIND_XF) && (out_idx == AW'(2))) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         vcount_ff    <= '0;
         have_ff      <= 1'b0;
         empty_ff     <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
               mat_ff[r][c] <= (r == c) ? ONE_Q : '0;
            end
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         vcount_ff    <= vcount_in;
         have_ff      <= have_in;
         empty_ff     <= empty_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mat_ff       <= mat_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff       <= dir_in;
      md_ff        <= md_in;
      p_ff         <= p_in;
      world_ff     <= world_in;
      best_ff      <= best_in;
      best_slot_ff <= best_slot_in;
      rd_slot_ff   <= rd_slot_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_world_x    = world_ff[0];
   assign rsp_world_y    = world_ff[1];
   assign rsp_world_z    = world_ff[2];
   assign rsp_empty_mesh = empty_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_XFORM_WAIT))
      else $error("result strobe without a finished world transform");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_QUERY)) |=> busy)
      else $error("query transfer did not start the sequencer");

   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (cnt_ff < n_eff))
      else $error("vertex walk beyond the vertex count");

endmodule

// ===== hdl/spmd_dot3.sv =====
module spmd_dot3 import spmd_pkg::*; #(
   parameter int TAG_W = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [TAG_W-1:0]        in_tag,
   input  logic signed [DATA_W-1:0] in_a [3],
   input  logic signed [DATA_W-1:0] in_b [3],
   input  logic signed [SUM_W-1:0] in_bias,
   output logic                    out_valid,
   output logic [TAG_W-1:0]        out_tag,
   output logic signed [SUM_W-1:0] out_sum
);

   logic signed [PROD_W-1:0] prod_ff [3];
   logic signed [PROD_W-1:0] prod_in [3];
   logic signed [SUM_W-1:0]  bias_ff;
   logic                     v1_ff;
   logic [TAG_W-1:0]         tag1_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;
   logic                     v2_ff;
   logic [TAG_W-1:0]         tag2_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod_in[k] = PROD_W'(in_a[k]) * PROD_W'(in_b[k]);
      end
      sum_in = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2]) + bias_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      bias_ff <= in_bias;
      tag1_ff <= in_tag;
      sum_ff  <= sum_in;
      tag2_ff <= tag1_ff;
   end

   assign out_valid = v2_ff;
   assign out_tag   = tag2_ff;
   assign out_sum   = sum_ff;

endmodule

// ===== hdl/spmd_vmem.sv =====
module spmd_vmem import spmd_pkg::*; #(
   parameter int DEPTH = MAX_VERTICES_DEF,
   parameter int AW    = $clog2(MAX_VERTICES_DEF)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [VEC_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [VEC_W-1:0] rd_data
);

   logic [VEC_W-1:0] vtx_mem [DEPTH];
   logic [VEC_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vtx_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= vtx_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== bench/tb_support_point_max_dot.sv =====
`timescale 1ns / 100ps

module tb_support_point_max_dot;
   import spmd_pkg::*;

   localparam int MAXV         = MAX_VERTICES_DEF;
   localparam int FRAC         = FRAC_BITS_DEF;
   localparam int RANDOM_ITEMS = 570;
   localparam int STALL_LIMIT  = 6000;

   // action 3 has no meaning in the block and is dropped
   localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

   typedef logic signed [DATA_W-1:0] q_t;
   typedef logic signed [69:0] wide_t;

   localparam q_t MAXQ = 32'sh7fff_ffff;
   localparam q_t MINQ = 32'sh8000_0000;
   localparam q_t ONE  = 32'sh0001_0000;
   localparam wide_t W_MAX = 70'sd2147483647;
   localparam wide_t W_MIN = -70'sd2147483648;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [IDX_W-1:0] index;
      q_t               a;
      q_t               b;
      q_t               c;
      q_t               d;
   } req_t;

   typedef struct packed {
      q_t   x;
      q_t   y;
      q_t   z;
      logic empty;
   } world_pt_t;

   typedef struct packed {
      logic             set_count;
      logic [CSR_W-1:0] count;
      req_t             req;
      logic             known;
      world_pt_t        pt;
   } step_t;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [ACT_W-1:0]         req_action;
   logic [IDX_W-1:0]         req_index;
   logic signed [DATA_W-1:0] req_val_a;
   logic signed [DATA_W-1:0] req_val_b;
   logic signed [DATA_W-1:0] req_val_c;
   logic signed [DATA_W-1:0] req_val_d;
   logic                     csr_we;
   logic [CSR_W-1:0]         csr_wdata;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_world_x;
   logic signed [DATA_W-1:0] rsp_world_y;
   logic signed [DATA_W-1:0] rsp_world_z;
   logic                     rsp_empty_mesh;

   support_point_max_dot dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_index      (req_index),
      .req_val_a      (req_val_a),
      .req_val_b      (req_val_b),
      .req_val_c      (req_val_c),
      .req_val_d      (req_val_d),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_world_x    (rsp_world_x),
      .rsp_world_y    (rsp_world_y),
      .rsp_world_z    (rsp_world_z),
      .rsp_empty_mesh (rsp_empty_mesh)
   );

   always #5 clock = ~clock;

   // mirror of the block's state
   q_t               mesh_pt [MAXV][3];
   bit               written [MAXV];
   q_t               model_rows [3][4];
   logic [CSR_W-1:0] mesh_size;

   world_pt_t pending_points [$];
   step_t     directed_plan [$];
   int        mismatches = 0;
   int        stall_cycles = 0;
   bit        no_idle = 1'b0;
   world_pt_t head_pt;

   function automatic q_t floor_sat(input wide_t s);
      wide_t sh;
      sh = s >>> FRAC;
      if (sh > W_MAX) return MAXQ;
      if (sh < W_MIN) return MINQ;
      return sh[DATA_W-1:0];
   endfunction

   function automatic world_pt_t support_world_point(input q_t dx, input q_t dy, input q_t dz);
      world_pt_t pt;
      q_t        dir [3];
      q_t        md [3];
      q_t        p [3];
      q_t        w [3];
      wide_t     acc;
      wide_t     dot;
      wide_t     best;
      int        n;
      int        win;
      dir[0] = dx;
      dir[1] = dy;
      dir[2] = dz;
      // direction into model space through the transposed rotation
      for (int k = 0; k < 3; k++) begin
         acc = '0;
         for (int r = 0; r < 3; r++) acc = acc + model_rows[r][k] * dir[r];
         md[k] = floor_sat(acc);
      end
      n = (mesh_size > MAXV) ? MAXV : int'(mesh_size);
      best = '0;
      win = 0;
      for (int i = 0; i < n; i++) begin
         dot = '0;
         for (int k = 0; k < 3; k++) dot = dot + mesh_pt[i][k] * md[k];
         // strictly greater: the first of equal dots stays
         if (i == 0 || dot > best) begin
            best = dot;
            win = i;
         end
      end
      for (int k = 0; k < 3; k++) p[k] = (n == 0) ? q_t'(0) : mesh_pt[win][k];
      for (int r = 0; r < 3; r++) begin
         acc = model_rows[r][3];
         acc = acc <<< FRAC;
         for (int k = 0; k < 3; k++) acc = acc + model_rows[r][k] * p[k];
         w[r] = floor_sat(acc);
      end
      pt.x = w[0];
      pt.y = w[1];
      pt.z = w[2];
      pt.empty = (n == 0);
      return pt;
   endfunction

   function automatic void take_request(input req_t rq, output bit hit, output world_pt_t pt);
      hit = 1'b0;
      pt = '0;
      case (rq.action)
         ACT_LOAD_VTX: begin
            mesh_pt[rq.index][0] = rq.a;
            mesh_pt[rq.index][1] = rq.b;
            mesh_pt[rq.index][2] = rq.c;
            written[rq.index] = 1'b1;
         end
         ACT_LOAD_ROW: begin
            if (rq.index < 3) begin
               model_rows[rq.index][0] = rq.a;
               model_rows[rq.index][1] = rq.b;
               model_rows[rq.index][2] = rq.c;
               model_rows[rq.index][3] = rq.d;
            end
         end
         ACT_QUERY: begin
            hit = 1'b1;
            pt = support_world_point(rq.a, rq.b, rq.c);
         end
         default: ;
      endcase
   endfunction

   function automatic req_t make_req(input logic [ACT_W-1:0] act, input int idx,
                                     input q_t a, input q_t b, input q_t c, input q_t d);
      req_t rq;
      rq.action = act;
      rq.index = idx[IDX_W-1:0];
      rq.a = a;
      rq.b = b;
      rq.c = c;
      rq.d = d;
      return rq;
   endfunction

   function automatic void plan_req(input logic [ACT_W-1:0] act, input int idx,
                                    input q_t a, input q_t b, input q_t c, input q_t d);
      step_t st;
      st = '0;
      st.req = make_req(act, idx, a, b, c, d);
      directed_plan.push_back(st);
   endfunction

   function automatic void plan_known(input q_t dx, input q_t dy, input q_t dz,
                                      input q_t wx, input q_t wy, input q_t wz, input logic e);
      step_t st;
      st = '0;
      st.req = make_req(ACT_QUERY, 0, dx, dy, dz, 0);
      st.known = 1'b1;
      st.pt.x = wx;
      st.pt.y = wy;
      st.pt.z = wz;
      st.pt.empty = e;
      directed_plan.push_back(st);
   endfunction

   function automatic void plan_count(input int n);
      step_t st;
      st = '0;
      st.set_count = 1'b1;
      st.count = n[CSR_W-1:0];
      directed_plan.push_back(st);
   endfunction

   function automatic q_t pick_q();
      q_t v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 5))
               0: return MAXQ;
               1: return MINQ;
               2: return 0;
               3: return ONE;
               4: return -ONE;
               default: return -1;
            endcase
         end
         1, 2, 3: return $urandom;
         4, 5: begin
            // whole numbers near zero, so that ties happen
            v = $urandom_range(0, 4);
            return (v - 2) <<< FRAC;
         end
         default: begin
            v = $urandom_range(0, 32'h0010_0000);
            return v - 32'sh0008_0000;
         end
      endcase
   endfunction

   function automatic int next_gap();
      return no_idle ? 0 : $urandom_range(0, 8);
   endfunction

   task automatic drive_request(input req_t rq, input int gap, input bit known,
                                input world_pt_t known_pt);
      bit        hit;
      world_pt_t pt;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start      <= 1'b1;
      req_action <= rq.action;
      req_index  <= rq.index;
      req_val_a  <= rq.a;
      req_val_b  <= rq.b;
      req_val_c  <= rq.c;
      req_val_d  <= rq.d;
      do @(posedge clock); while (busy);
      take_request(rq, hit, pt);
      if (hit) pending_points.push_back(known ? known_pt : pt);
   endtask

   // stop sending and wait until every expected result has been seen
   task automatic drain_results(input int pause);
      @(negedge clock);
      start <= 1'b0;
      while (pending_points.size() != 0 || busy) @(posedge clock);
      repeat (pause) @(posedge clock);
   endtask

   task automatic write_mesh_size(input int n);
      drain_results(24);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= n[CSR_W-1:0];
      @(posedge clock);
      mesh_size = n[CSR_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v,
                              input logic [DATA_W-1:0] got_v);
      if (exp_v !== got_v) begin
         $error("%s: expected %h, got %h", name, exp_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_points.size() == 0) begin
            $error("result transfer with nothing expected");
            mismatches++;
         end else begin
            head_pt = pending_points.pop_front();
            check_field("world_x", head_pt.x, rsp_world_x);
            check_field("world_y", head_pt.y, rsp_world_y);
            check_field("world_z", head_pt.z, rsp_world_z);
            check_field("empty_mesh", {31'b0, head_pt.empty}, {31'b0, rsp_empty_mesh});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("tb_support_point_max_dot failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      req_t      rq;
      world_pt_t none;
      int        n;
      int        lim;
      int        k;
      int        r;
      int        items_sent;
      int        big_step;
      bit        big;

      reset = 1'b1;
      start = 1'b0;
      req_action = ACT_LOAD_VTX;
      req_index = '0;
      req_val_a = '0;
      req_val_b = '0;
      req_val_c = '0;
      req_val_d = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      none = '0;
      for (int i = 0; i < MAXV; i++) begin
         for (int j = 0; j < 3; j++) mesh_pt[i][j] = 0;
         written[i] = 1'b0;
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 4; j++) model_rows[i][j] = (i == j) ? ONE : q_t'(0);
      mesh_size = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty mesh straight after reset: zero translation
      plan_known(ONE, 0, 0, 0, 0, 0, 1'b1);
      plan_req(ACT_SPARE, 1023, MAXQ, MINQ, MAXQ, MINQ);
      plan_req(ACT_LOAD_ROW, 3, MINQ, MINQ, MINQ, MINQ);
      plan_req(ACT_LOAD_ROW, 1023, MAXQ, MAXQ, MAXQ, MAXQ);
      plan_known(0, 0, 0, 0, 0, 0, 1'b1);
      plan_req(ACT_LOAD_VTX, 0, MAXQ, MINQ, 0, 0);
      plan_req(ACT_LOAD_VTX, 1, MINQ, MAXQ, MAXQ, MINQ);
      plan_req(ACT_LOAD_VTX, 2, 0, 0, 0, MAXQ);
      plan_req(ACT_LOAD_VTX, 3, ONE, 0, ONE, 0);
      plan_req(ACT_LOAD_VTX, 1023, 1, -1, 32'sh1234_5678, 0);
      plan_count(4);
      plan_known(ONE, 0, 0, MAXQ, MINQ, 0, 1'b0);
      plan_known(0, 0, 0, MAXQ, MINQ, 0, 1'b0);
      plan_known(-ONE, 0, 0, MINQ, MAXQ, MAXQ, 1'b0);
      // slots 2 and 3 tie at zero, the lower slot wins
      plan_known(ONE, ONE, -ONE, 0, 0, 0, 1'b0);
      plan_req(ACT_QUERY, 0, MINQ, MINQ, MINQ, MAXQ);
      plan_req(ACT_LOAD_ROW, 0, MAXQ, MAXQ, MAXQ, MAXQ);
      plan_req(ACT_LOAD_ROW, 1, MINQ, MINQ, MINQ, MINQ);
      plan_req(ACT_LOAD_ROW, 2, 0, 0, 0, 32'shffff_0000);
      plan_req(ACT_QUERY, 0, MAXQ, MAXQ, MAXQ, 0);
      plan_req(ACT_QUERY, 1023, MINQ, MINQ, MINQ, MAXQ);
      plan_count(1);
      plan_req(ACT_QUERY, 0, ONE, -ONE, 32'sh0000_8000, 0);
      plan_count(0);
      plan_known(MAXQ, MINQ, 1, MAXQ, MINQ, 32'shffff_0000, 1'b1);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].set_count)
            write_mesh_size(directed_plan[i].count);
         else
            drive_request(directed_plan[i].req, next_gap(), directed_plan[i].known,
                          directed_plan[i].pt);
      end

      items_sent = 0;
      big_step = 0;
      while (items_sent < RANDOM_ITEMS || big_step < 2) begin
         big = 1'b0;
         r = $urandom_range(0, 99);
         if (items_sent >= RANDOM_ITEMS / 2 && big_step < 2) begin
            // first time round this loads every slot, after that any size is safe
            n = (big_step == 0) ? MAXV : 2047;
            big_step++;
            big = 1'b1;
         end else if (r < 8) begin
            n = 0;
         end else if (r < 68) begin
            n = $urandom_range(1, 8);
         end else if (r < 93) begin
            n = $urandom_range(9, 64);
         end else if (r < 97 || big_step < 2) begin
            n = $urandom_range(65, 300);
         end else begin
            n = $urandom_range(1025, 2046);
            big = 1'b1;
         end
         no_idle = ($urandom_range(0, 3) == 0);
         write_mesh_size(n);
         lim = (n > MAXV) ? MAXV : n;

         for (int s = 0; s < lim; s++) begin
            if (!written[s] || (lim <= 64 && $urandom_range(0, 1) == 1)) begin
               rq = make_req(ACT_LOAD_VTX, s, pick_q(), pick_q(), pick_q(), $urandom);
               drive_request(rq, next_gap(), 1'b0, none);
               if (!big) items_sent++;
            end
         end

         k = big ? $urandom_range(2, 4) : $urandom_range(4, 20);
         for (int j = 0; j < k; j++) begin
            if ($urandom_range(0, 9) == 0) drain_results(0);
            r = $urandom_range(0, 99);
            if (r < 45) begin
               rq = make_req(ACT_QUERY, $urandom_range(0, 1023), pick_q(), pick_q(), pick_q(),
                             $urandom);
            end else if (r < 70) begin
               rq = make_req(ACT_LOAD_VTX,
                             (lim > 0) ? $urandom_range(0, lim - 1) : $urandom_range(0, 1023),
                             pick_q(), pick_q(), pick_q(), $urandom);
            end else if (r < 80) begin
               rq = make_req(ACT_LOAD_ROW, $urandom_range(0, 2), pick_q(), pick_q(), pick_q(),
                             pick_q());
            end else if (r < 88) begin
               rq = make_req(ACT_LOAD_ROW, $urandom_range(3, 1023), $urandom, $urandom,
                             $urandom, $urandom);
            end else if (r < 93) begin
               rq = make_req(ACT_SPARE, $urandom_range(0, 1023), $urandom, $urandom, $urandom,
                             $urandom);
            end else begin
               rq = make_req(ACT_LOAD_VTX, $urandom_range(0, 1023), pick_q(), pick_q(),
                             pick_q(), $urandom);
            end
            drive_request(rq, next_gap(), 1'b0, none);
            if (rq.action != ACT_SPARE && !(rq.action == ACT_LOAD_ROW && rq.index > 2))
               items_sent++;
         end
      end

      drain_results(40);
      if (mismatches == 0)
         $display("tb_support_point_max_dot passed");
      else
         $display("tb_support_point_max_dot failed");
      $finish;
   end

endmodule
